/* hw/rtl/grr_pkg.sv */
package grr_pkg;

	// register map, word index = paddr[4:2]
	localparam logic [2:0] REG_TEXT_COLOR   = 3'd0;
	localparam logic [2:0] REG_BACK_COLOR   = 3'd1;
	localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
	localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
	localparam logic [2:0] REG_ROTATION     = 3'd4;

	localparam logic [15:0] TEXT_COLOR_RST   = 16'd2016;
	localparam logic [15:0] BACK_COLOR_RST   = 16'd0;
	localparam logic [4:0]  GLYPH_WIDTH_RST  = 5'd11;
	localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
	localparam logic [1:0]  ROTATION_RST     = 2'd0;

	localparam logic [8:0] SHORT_SIDE = 9'd240;
	localparam logic [8:0] LONG_SIDE  = 9'd320;
	localparam logic [5:0] MAX_ROWS   = 6'd32;

	localparam int IN_W  = 56;
	localparam int OUT_W = 40;

	typedef struct packed {
		logic [15:0] text_color;
		logic [15:0] back_color;
		logic [4:0]  glyph_width;
		logic [5:0]  glyph_height;
		logic [1:0]  rotation;
	} grr_cfg_t;

	typedef struct packed {
		logic load;
		logic emit;
	} grr_cmd_t;

	typedef struct packed {
		logic none;      // item being offered draws nothing
		logic out_free;  // output register can take a pixel
		logic last_pix;  // one pixel left in this row
	} grr_sts_t;

endpackage

/* hw/rtl/grr_ctrl.sv */
module grr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  grr_pkg::grr_sts_t  sts,
	output logic               in_ready,
	output grr_pkg::grr_cmd_t  cmd
);
	import grr_pkg::*;

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready = (state_q == IDLE);
		cmd.load = (state_q == IDLE) && in_valid;
		cmd.emit = (state_q == RUN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid && !sts.none) begin
						state_q <= RUN;
					end
				end
				RUN: begin
					if (sts.out_free && sts.last_pix) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/grr_datapath.sv */
module grr_datapath #(
	parameter int MAX_GLYPH_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  grr_pkg::grr_cfg_t          cfg,
	input  grr_pkg::grr_cmd_t          cmd,
	output grr_pkg::grr_sts_t          sts,
	input  logic [grr_pkg::IN_W-1:0]   in_data,
	input  logic                       in_new_char,
	output logic                       out_valid,
	output logic [grr_pkg::OUT_W-1:0]  out_data,
	output logic                       out_last,
	input  logic                       out_ready
);
	import grr_pkg::*;

	localparam int CW = $clog2(MAX_GLYPH_WIDTH + 1);
	localparam int RW = 8 * ((MAX_GLYPH_WIDTH + 7) / 8);

	logic [15:0]   cx, cy;
	logic [RW-1:0] bits_in, bits_al;
	logic [CW-1:0] w_eff, n;
	logic [5:0]    wx, top_w, sh, h_eff, next_row;
	logic [4:0]    ri_cur;
	logic [16:0]   py;
	logic [8:0]    scr_w, scr_h, avail;
	logic          x_ok, y_ok;

	logic [4:0]    row_q;
	logic [8:0]    px_q, py_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] sr_q;

	logic          valid_q, last_q;
	logic [8:0]    pix_x_q, pix_y_q;
	logic [15:0]   pix_color_q;

	always_comb begin
		cx      = in_data[15:0];
		cy      = in_data[31:16];
		bits_in = in_data[32 +: RW];

		w_eff = (32'(cfg.glyph_width) > MAX_GLYPH_WIDTH) ? CW'(MAX_GLYPH_WIDTH)
		                                                 : CW'(cfg.glyph_width);
		h_eff = (cfg.glyph_height == 6'd0 || cfg.glyph_height > MAX_ROWS) ? MAX_ROWS
		                                                                  : cfg.glyph_height;

		// bytes on the wire sit in the low bits; left-align them in the shifter
		wx      = 6'(w_eff) + 6'd7;
		top_w   = {wx[5:3], 3'b000};
		sh      = 6'(RW) - top_w;
		bits_al = bits_in << sh;

		scr_w = cfg.rotation[0] ? LONG_SIDE : SHORT_SIDE;
		scr_h = cfg.rotation[0] ? SHORT_SIDE : LONG_SIDE;

		ri_cur = in_new_char ? 5'd0 : row_q;
		py     = {1'b0, cy} + {12'd0, ri_cur};
		y_ok   = py < {8'd0, scr_h};
		x_ok   = cx < {7'd0, scr_w};
		avail  = scr_w - cx[8:0];

		if (!(x_ok && y_ok)) begin
			n = '0;
		end else if (avail < 9'(w_eff)) begin
			n = CW'(avail);
		end else begin
			n = w_eff;
		end

		next_row = {1'b0, ri_cur} + 6'd1;

		sts.none     = (n == '0);
		sts.out_free = !valid_q || out_ready;
		sts.last_pix = (cnt_q == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.load) begin
			row_q <= (next_row >= h_eff) ? 5'd0 : next_row[4:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q  <= cx[8:0];
			py_q  <= py[8:0];
			cnt_q <= n;
			sr_q  <= bits_al;
		end else if (cmd.emit) begin
			px_q  <= px_q + 9'd1;
			cnt_q <= cnt_q - CW'(1);
			sr_q  <= sr_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pix_x_q     <= px_q;
			pix_y_q     <= py_q;
			pix_color_q <= sr_q[RW-1] ? cfg.text_color : cfg.back_color;
			last_q      <= (cnt_q == CW'(1));
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {6'd0, pix_color_q, pix_y_q, pix_x_q};
	assign out_last  = last_q;

endmodule

/* hw/rtl/glyph_row_rasterizer.sv */
// Channel | Dir | Carries
// s_*     | in  | tdata: char_x[15:0] char_y[31:16] row_bits[55:32]; tuser: new_char
// m_*     | out | tdata: pixel_x[8:0] pixel_y[17:9] pixel_color[33:18]; tlast: last
// apb     | in  | five config registers at byte offsets 0,4,8,12,16
//
// One row item draws n = min(glyph width, columns left before the screen edge)
// pixels, or none when the row or the first column is off screen.
// An item is loaded first, then the column counter and bit shifter give one pixel
// per cycle. Backpressure on m_ stretches the run.
// Reset sets the registers to their defaults and the row counter to zero.
module glyph_row_rasterizer #(
	parameter int MAX_GLYPH_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // char_x, char_y, row_bits
	input  logic        s_tuser,   // new_char

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // pixel_x, pixel_y, pixel_color, zero pad
	output logic        m_tlast,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import grr_pkg::*;

	grr_cfg_t   cfg_q;
	grr_cmd_t   cmd;
	grr_sts_t   sts;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color   <= TEXT_COLOR_RST;
			cfg_q.back_color   <= BACK_COLOR_RST;
			cfg_q.glyph_width  <= GLYPH_WIDTH_RST;
			cfg_q.glyph_height <= GLYPH_HEIGHT_RST;
			cfg_q.rotation     <= ROTATION_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TEXT_COLOR:   cfg_q.text_color   <= pwdata[15:0];
				REG_BACK_COLOR:   cfg_q.back_color   <= pwdata[15:0];
				REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= pwdata[4:0];
				REG_GLYPH_HEIGHT: cfg_q.glyph_height <= pwdata[5:0];
				REG_ROTATION:     cfg_q.rotation     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TEXT_COLOR:   prdata = {16'd0, cfg_q.text_color};
			REG_BACK_COLOR:   prdata = {16'd0, cfg_q.back_color};
			REG_GLYPH_WIDTH:  prdata = {27'd0, cfg_q.glyph_width};
			REG_GLYPH_HEIGHT: prdata = {26'd0, cfg_q.glyph_height};
			REG_ROTATION:     prdata = {30'd0, cfg_q.rotation};
			default:          prdata = 32'd0;
		endcase
	end

	grr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	grr_datapath #(
		.MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.in_data     (s_tdata),
		.in_new_char (s_tuser),
		.out_valid   (m_tvalid),
		.out_data    (m_tdata),
		.out_last    (m_tlast),
		.out_ready   (m_tready)
	);

`ifndef SYNTHESIS
	// pixels never leave the screen set by rotation
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] < (cfg_q.rotation[0] ? LONG_SIDE : SHORT_SIDE)) &&
		             (m_tdata[17:9] < (cfg_q.rotation[0] ? SHORT_SIDE : LONG_SIDE)))
		else $error("pixel outside screen bounds");

	// while a row is only partly delivered no new item is taken
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input accepted in the middle of a row");

	// columns within a row step by one
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(!m_tvalid || (m_tdata[8:0] == $past(m_tdata[8:0]) + 9'd1)))
		else $error("pixel column did not advance by one");
`endif

endmodule

/* tb/sv/tb_glyph_row_rasterizer.sv */
`timescale 1ns / 100ps

module tb_glyph_row_rasterizer;
	import grr_pkg::*;

	localparam int unsigned WIDEST = 24;
	localparam logic [2:0] REG_UNMAPPED = 3'd5;
	localparam int unsigned RANDOM_ROWS = 88;
	localparam int unsigned SETTLE_CYCLES = 40;

	typedef struct packed {
		logic        last;
		logic [15:0] color;
		logic [8:0]  y;
		logic [8:0]  x;
	} pixel_t;

	class pixel_ledger;
		logic [15:0] ink;
		logic [15:0] paper;
		logic [4:0]  cols;
		logic [5:0]  rows_per_glyph;
		logic [1:0]  orient;
		int unsigned cur_row;
		int unsigned faults;
		pixel_t      pending[$];

		function new();
			ink = TEXT_COLOR_RST;
			paper = BACK_COLOR_RST;
			cols = GLYPH_WIDTH_RST;
			rows_per_glyph = GLYPH_HEIGHT_RST;
			orient = ROTATION_RST;
			cur_row = 0;
			faults = 0;
		endfunction

		task note(string msg);
			faults++;
			$display("%0t ERROR %s", $time, msg);
		endtask

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_TEXT_COLOR:   ink = val[15:0];
				REG_BACK_COLOR:   paper = val[15:0];
				REG_GLYPH_WIDTH:  cols = val[4:0];
				REG_GLYPH_HEIGHT: rows_per_glyph = val[5:0];
				REG_ROTATION:     orient = val[1:0];
				default: ;
			endcase
		endfunction

		// expected pixels for one accepted glyph row
		function void draw_row(logic [15:0] cx, logic [15:0] cy, logic [23:0] bits,
				logic restart);
			int unsigned w, h, top, span_x, span_y, py, px, j;
			pixel_t p;
			if (restart)
				cur_row = 0;
			w = 32'(cols);
			if (w > WIDEST)
				w = WIDEST;
			h = 32'(rows_per_glyph);
			if (h == 0 || h > 32)
				h = 32;
			span_x = 32'(orient[0] ? LONG_SIDE : SHORT_SIDE);
			span_y = 32'(orient[0] ? SHORT_SIDE : LONG_SIDE);
			top = 8 * ((w + 7) / 8);
			py = 32'(cy) + cur_row;
			if (py < span_y) begin
				for (j = 0; j < w && 32'(cx) + j < span_x; j++) begin
					px = 32'(cx) + j;
					p.x = px[8:0];
					p.y = py[8:0];
					p.color = bits[top - 1 - j] ? ink : paper;
					p.last = (j + 1 == w) || (px + 1 >= span_x);
					pending.push_back(p);
				end
			end
			cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
		endfunction

		task take_pixel(logic [8:0] x, logic [8:0] y, logic [15:0] color,
				logic last);
			pixel_t e;
			if (pending.size() == 0) begin
				note($sformatf("pixel with nothing pending x=%0d y=%0d color=%h", x, y, color));
				return;
			end
			e = pending.pop_front();
			if (x !== e.x)
				note($sformatf("pixel_x %0d, want %0d", x, e.x));
			if (y !== e.y)
				note($sformatf("pixel_y %0d, want %0d (x=%0d)", y, e.y, e.x));
			if (color !== e.color)
				note($sformatf("pixel_color %h, want %h (x=%0d y=%0d)", color, e.color, e.x, e.y));
			if (last !== e.last)
				note($sformatf("tlast %b, want %b (x=%0d y=%0d)", last, e.last, e.x, e.y));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;    // char_x[15:0], char_y[31:16], row_bits[55:32]
	logic        s_tuser = 1'b0;  // new_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // pixel_x[8:0], pixel_y[17:9], pixel_color[33:18], pad
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pixel_ledger board;
	bit          calm = 1'b0;
	int unsigned rows_sent = 0;

	glyph_row_rasterizer #(
		.MAX_GLYPH_WIDTH(WIDEST)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int  run;
		bit  rdy;
		run = 0;
		forever begin
			@(posedge clk);
			if (calm) begin
				m_tready <= 1'b1;
			end else if (run > 0) begin
				run--;
			end else begin
				rdy = $urandom_range(0, 3) != 0;
				run = rdy ? $urandom_range(0, 15) : idle_len();
				m_tready <= rdy;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.take_pixel(m_tdata[8:0], m_tdata[17:9], m_tdata[33:18], m_tlast);
	end

	task automatic row_item(logic [15:0] cx, logic [15:0] cy, logic [23:0] bits, logic nc);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {bits, cy, cx};
		s_tuser <= nc;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.draw_row(cx, cy, bits, nc);
		rows_sent++;
	endtask

	// drop valid and let every pending pixel drain, then allow the tail of an empty row
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_setup();
		logic [4:0] w;
		logic [5:0] h;
		w = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 24));
		h = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 10));
		apb_write(REG_TEXT_COLOR, $urandom);
		apb_write(REG_BACK_COLOR, $urandom);
		apb_write(REG_GLYPH_WIDTH, 32'(w));
		apb_write(REG_GLYPH_HEIGHT, 32'(h));
		apb_write(REG_ROTATION, $urandom_range(0, 3));
	endtask

	// one glyph: new_char on the first row, same origin throughout, sometimes cut short
	task automatic send_glyph();
		int unsigned h, rows, r, sx, sy;
		logic [15:0] cx, cy;
		sx = 32'(board.orient[0] ? LONG_SIDE : SHORT_SIDE);
		sy = 32'(board.orient[0] ? SHORT_SIDE : LONG_SIDE);
		h = 32'(board.rows_per_glyph);
		if (h == 0 || h > 32)
			h = 32;
		rows = ($urandom_range(0, 4) == 0) ? $urandom_range(1, h) : h;
		if ($urandom_range(0, 3) == 0) begin
			cx = 16'(sx - $urandom_range(1, 30));
			cy = 16'(sy - $urandom_range(1, 40));
		end else begin
			cx = 16'($urandom_range(0, sx + 4));
			cy = 16'($urandom_range(0, sy + 2));
		end
		for (r = 0; r < rows; r++)
			row_item(cx, cy, 24'($urandom), r == 0);
	endtask

	initial begin
		int unsigned phase, phase_start;
		bit paused;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 11 wide, 16 high, 240x320
		row_item(16'd0, 16'd0, 24'hFFA55F, 1'b1);      // unused top byte set
		row_item(16'd229, 16'd0, 24'h00FFFF, 1'b0);    // ends exactly at the right edge
		row_item(16'd230, 16'd0, 24'h00AAAA, 1'b0);    // clipped by one column
		row_item(16'd240, 16'd0, 24'hFFFFFF, 1'b0);    // first column off screen
		row_item(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0);
		row_item(16'd100, 16'd319, 24'h000000, 1'b1);  // bottom screen row
		row_item(16'd100, 16'd319, 24'hFFFFFF, 1'b0);  // one row below the screen
		settle();
		apb_write(REG_TEXT_COLOR, 32'h0000FFFF);
		apb_write(REG_BACK_COLOR, 32'h00000000);
		apb_write(REG_GLYPH_WIDTH, 32'd24);
		apb_write(REG_GLYPH_HEIGHT, 32'd1);   // below the current row
		apb_write(REG_ROTATION, 32'd1);
		row_item(16'd296, 16'd239, 24'h800001, 1'b0);
		row_item(16'd296, 16'd239, 24'h800001, 1'b0);
		row_item(16'd0, 16'd0, 24'h123456, 1'b1);
		settle();
		apb_write(REG_TEXT_COLOR, 32'h00000000);
		apb_write(REG_BACK_COLOR, 32'hFFFFFFFF);
		apb_write(REG_GLYPH_WIDTH, 32'd0);
		row_item(16'd0, 16'd0, 24'hFFFFFF, 1'b0);      // zero width draws nothing
		settle();
		apb_write(REG_GLYPH_WIDTH, 32'd31);   // clamps to the widest glyph
		apb_write(REG_GLYPH_HEIGHT, 32'd0);   // means 32 rows
		apb_write(REG_ROTATION, 32'd2);
		apb_write(REG_UNMAPPED, 32'hFFFFFFFF);
		row_item(16'd216, 16'd0, 24'hC33CA5, 1'b1);
		row_item(16'd0, 16'd288, 24'h5A5A5A, 1'b0);
		settle();
		apb_write(REG_GLYPH_WIDTH, 32'd1);
		apb_write(REG_GLYPH_HEIGHT, 32'd63);
		apb_write(REG_ROTATION, 32'd3);
		row_item(16'd319, 16'd0, 24'h000080, 1'b1);
		row_item(16'd319, 16'd0, 24'hFFFF7F, 1'b0);
		settle();
		apb_write(REG_GLYPH_WIDTH, 32'd8);
		apb_write(REG_GLYPH_HEIGHT, 32'd2);
		row_item(16'd312, 16'd238, 24'hFFFF81, 1'b0);
		row_item(16'd312, 16'd238, 24'h000081, 1'b0);
		row_item(16'd312, 16'd238, 24'h00007E, 1'b0);
		settle();
		apb_write(REG_TEXT_COLOR, 32'(TEXT_COLOR_RST));
		apb_write(REG_GLYPH_WIDTH, 32'd9);
		apb_write(REG_GLYPH_HEIGHT, 32'd16);
		apb_write(REG_ROTATION, 32'd0);
		row_item(16'd231, 16'd0, 24'h00FF80, 1'b1);
		row_item(16'd232, 16'd0, 24'h00FF80, 1'b0);

		phase = 0;
		paused = 1'b0;
		phase_start = rows_sent;
		while (rows_sent < phase_start + RANDOM_ROWS) begin
			int unsigned here;
			settle();
			random_setup();
			calm = (phase == 1);
			here = rows_sent;
			while (rows_sent < here + 22) begin
				if ($urandom_range(0, 4) == 0)
					row_item(16'($urandom), 16'($urandom), 24'($urandom),
						1'($urandom_range(0, 1)));
				else
					send_glyph();
				if (phase == 2 && !paused && rows_sent >= here + 10) begin
					settle();
					paused = 1'b1;
				end
			end
			calm = 1'b0;
			phase++;
		end

		settle();
		if (board.pending.size() != 0)
			board.note($sformatf("%0d pixels never arrived", board.pending.size()));
		if (board.faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
